// File: rtl/core/cqig_pkg.sv
// ----------------------------------------------------------------------------
// cqig_pkg
// Shared constants and types of the cylinder quad index generator.
// ----------------------------------------------------------------------------
package cqig_pkg;

    localparam int MAX_AROUND = 1024;
    localparam int MAX_RINGS  = 1024;

    localparam int CFG_W  = 11;
    localparam int CNT_W  = 10;
    localparam int IDX_W  = 21;
    localparam int SEC_W  = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [SEC_W-1:0] SEC_BOTTOM = 2'd0;
    localparam logic [SEC_W-1:0] SEC_BODY   = 2'd1;
    localparam logic [SEC_W-1:0] SEC_TOP    = 2'd2;

    localparam logic [1:0] REG_AROUND = 2'd0;
    localparam logic [1:0] REG_RINGS  = 2'd1;
    localparam logic [1:0] REG_CLOSED = 2'd2;

    localparam logic [CFG_W-1:0] AROUND_RST = 11'd16;
    localparam logic [CFG_W-1:0] RINGS_RST  = 11'd2;

    // Effective mesh geometry after saturation
    typedef struct packed {
        logic [CFG_W-1:0] n;
        logic [CFG_W-1:0] r;
        logic             closed;
        logic [IDX_W-1:0] center;
        logic [CNT_W-1:0] caps;
    } geom_t;

    // Sequence position
    typedef struct packed {
        logic [SEC_W-1:0] phase;
        logic [CNT_W-1:0] column;
        logic [CNT_W-1:0] row;
        logic [IDX_W-1:0] row_base;
    } seq_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
        logic [IDX_W-1:0] idx_c;
        logic [IDX_W-1:0] idx_d;
        logic [SEC_W-1:0] section;
        logic             last_quad;
    } quad_t;

endpackage

// File: rtl/core/cylinder_quad_index_generator_top.sv
// quad_valid rises in the cycle after the request transfer. Throughput: one
//   quad per cycle unless quad_stall holds a result; the position registers
//   advance at each request transfer, the result register frees as it is taken.
// Reset: sizes 16 around, 2 rings, open mesh; sequence at the first quad,
//   result register empty. A register write restarts the sequence.
// ----------------------------------------------------------------------------
// cylinder_quad_index_generator_top
// Cylinder mesh quad index generator: one quad per request.
// ----------------------------------------------------------------------------
module cylinder_quad_index_generator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cqig_pkg::ADDR_W-1:0] paddr,
    input  logic [cqig_pkg::DATA_W-1:0] pwdata,
    output logic [cqig_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic                        restart,
    output logic                        quad_valid,
    input  logic                        quad_stall,
    output logic [cqig_pkg::IDX_W-1:0]  idx_a,
    output logic [cqig_pkg::IDX_W-1:0]  idx_b,
    output logic [cqig_pkg::IDX_W-1:0]  idx_c,
    output logic [cqig_pkg::IDX_W-1:0]  idx_d,
    output logic [cqig_pkg::SEC_W-1:0]  section,
    output logic                        last_quad
);
    import cqig_pkg::*;

    geom_t geom;
    logic  cfg_wr;
    seq_t  seq_reg;
    seq_t  seq_next;
    quad_t quad_next;
    quad_t quad_reg;
    logic  pend_reg;
    logic  valid_reg;
    logic  valid_next;
    logic  take;

    assign pready = 1'b1;

    cqig_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg_wr  (cfg_wr),
        .geom    (geom)
    );

    // pending restart covers reset and register writes, so the first
    // position follows the closed setting in force at the next transfer
    cqig_quad u_quad (
        .geom     (geom),
        .seq      (seq_reg),
        .restart  (restart | pend_reg),
        .seq_next (seq_next),
        .quad     (quad_next)
    );

    assign req_stall  = valid_reg & quad_stall;
    assign take       = req_valid & ~req_stall;
    assign valid_next = take | (valid_reg & quad_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg.phase    <= SEC_BODY;
            seq_reg.column   <= '0;
            seq_reg.row      <= '0;
            seq_reg.row_base <= '0;
            pend_reg         <= 1'b1;
            valid_reg        <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_wr)
                pend_reg <= 1'b1;
            else if (take)
            begin
                pend_reg <= 1'b0;
                seq_reg  <= seq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            quad_reg <= quad_next;
    end

    assign quad_valid = valid_reg;
    assign idx_a      = quad_reg.idx_a;
    assign idx_b      = quad_reg.idx_b;
    assign idx_c      = quad_reg.idx_c;
    assign idx_d      = quad_reg.idx_d;
    assign section    = quad_reg.section;
    assign last_quad  = quad_reg.last_quad;

endmodule

// File: rtl/core/cqig_cfg.sv
// ----------------------------------------------------------------------------
// cqig_cfg
// Register file on the APB-style port; saturates the sizes and derives the
// cap center vertex and the cap quad count.
// ----------------------------------------------------------------------------
module cqig_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cqig_pkg::ADDR_W-1:0] paddr,
    input  logic [cqig_pkg::DATA_W-1:0] pwdata,
    output logic [cqig_pkg::DATA_W-1:0] prdata,
    output logic                       cfg_wr,
    output cqig_pkg::geom_t            geom
);
    import cqig_pkg::*;

    logic [CFG_W-1:0]   around_reg;
    logic [CFG_W-1:0]   rings_reg;
    logic               closed_reg;
    logic [1:0]         reg_sel;
    logic [CFG_W-1:0]   n_eff;
    logic [CFG_W-1:0]   r_eff;
    logic [2*CFG_W-1:0] prod;

    assign reg_sel = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            around_reg <= AROUND_RST;
            rings_reg  <= RINGS_RST;
            closed_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_AROUND: around_reg <= pwdata[CFG_W-1:0];
                REG_RINGS:  rings_reg  <= pwdata[CFG_W-1:0];
                REG_CLOSED: closed_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_AROUND: prdata = DATA_W'(around_reg);
            REG_RINGS:  prdata = DATA_W'(rings_reg);
            REG_CLOSED: prdata = DATA_W'(closed_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        if (around_reg < CFG_W'(2))
            n_eff = CFG_W'(2);
        else if (around_reg > CFG_W'(MAX_AROUND))
            n_eff = CFG_W'(MAX_AROUND);
        else
            n_eff = around_reg;

        if (rings_reg < CFG_W'(2))
            r_eff = CFG_W'(2);
        else if (rings_reg > CFG_W'(MAX_RINGS))
            r_eff = CFG_W'(MAX_RINGS);
        else
            r_eff = rings_reg;
    end

    assign prod = (2*CFG_W)'(n_eff) * (2*CFG_W)'(r_eff);

    assign geom.n      = n_eff;
    assign geom.r      = r_eff;
    assign geom.closed = closed_reg;
    assign geom.center = prod[IDX_W-1:0];
    assign geom.caps   = n_eff[CNT_W:1];

endmodule

// File: rtl/core/cqig_quad.sv
// ----------------------------------------------------------------------------
// cqig_quad
// Quad index logic: builds one quad from the sequence position and gives the
// next position.
// ----------------------------------------------------------------------------
module cqig_quad (
    input  cqig_pkg::geom_t geom,
    input  cqig_pkg::seq_t  seq,
    input  logic            restart,
    output cqig_pkg::seq_t  seq_next,
    output cqig_pkg::quad_t quad
);
    import cqig_pkg::*;

    seq_t             cur;
    seq_t             first;
    logic [CFG_W-1:0] x1;
    logic [CFG_W-1:0] row2;
    logic             fin_cap;
    logic             wrap;
    logic             row_end;
    logic [IDX_W-1:0] xw;
    logic [IDX_W-1:0] nw;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] st;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] lox;
    logic [IDX_W-1:0] hix;

    always_comb
    begin
        first.phase    = geom.closed ? SEC_BOTTOM : SEC_BODY;
        first.column   = '0;
        first.row      = '0;
        first.row_base = '0;
    end

    // an open mesh never sits in a cap section
    assign cur = (restart || (!geom.closed && seq.phase != SEC_BODY)) ? first : seq;

    assign x1      = CFG_W'(cur.column) + CFG_W'(1);
    assign row2    = CFG_W'(cur.row) + CFG_W'(2);
    assign fin_cap = x1 >= CFG_W'(geom.caps);
    assign wrap    = x1 >= geom.n;
    assign row_end = row2 >= geom.r;

    assign xw  = IDX_W'(cur.column);
    assign nw  = IDX_W'(geom.n);
    assign j   = xw << 1;
    assign s   = geom.center - nw;
    assign st  = s + j;
    assign lo  = cur.row_base;
    assign hi  = cur.row_base + nw;
    assign lox = lo + xw;
    assign hix = hi + xw;

    always_comb
    begin
        seq_next        = cur;
        quad.section    = cur.phase;
        quad.last_quad  = 1'b0;
        case (cur.phase)
            SEC_BOTTOM:
            begin
                quad.idx_a = geom.center;
                quad.idx_b = j;
                quad.idx_c = j + IDX_W'(1);
                quad.idx_d = fin_cap ? '0 : j + IDX_W'(2);
                if (fin_cap)
                begin
                    seq_next.phase    = SEC_BODY;
                    seq_next.column   = '0;
                    seq_next.row      = '0;
                    seq_next.row_base = '0;
                end
                else
                    seq_next.column = cur.column + CNT_W'(1);
            end
            SEC_TOP:
            begin
                quad.idx_a = geom.center + IDX_W'(1);
                quad.idx_b = fin_cap ? s : st + IDX_W'(2);
                quad.idx_c = st + IDX_W'(1);
                quad.idx_d = st;
                if (fin_cap)
                begin
                    quad.last_quad = 1'b1;
                    seq_next       = first;
                end
                else
                    seq_next.column = cur.column + CNT_W'(1);
            end
            default:
            begin
                quad.idx_a = lox;
                quad.idx_b = hix;
                quad.idx_c = wrap ? hi : hix + IDX_W'(1);
                quad.idx_d = wrap ? lo : lox + IDX_W'(1);
                if (wrap)
                begin
                    if (row_end)
                    begin
                        if (geom.closed)
                        begin
                            seq_next.phase    = SEC_TOP;
                            seq_next.column   = '0;
                            seq_next.row      = '0;
                            seq_next.row_base = '0;
                        end
                        else
                        begin
                            quad.last_quad = 1'b1;
                            seq_next       = first;
                        end
                    end
                    else
                    begin
                        seq_next.column   = '0;
                        seq_next.row      = cur.row + CNT_W'(1);
                        seq_next.row_base = hi;
                    end
                end
                else
                    seq_next.column = cur.column + CNT_W'(1);
            end
        endcase
    end

endmodule

// File: tb/sv/cylinder_quad_index_generator_top_tb.sv
// ----------------------------------------------------------------------------
// cylinder_quad_index_generator_top_tb
// Self-checking bench for the cylinder quad index generator. A directed table
// covers reset sizes, restart, open and closed meshes, saturated and odd
// sizes and the largest mesh. Random meshes with random restarts follow under
// three idle/stall mixes and one long output hold. Every quad is compared
// field by field with its table entry or an in-bench model of the index sequence.
// ----------------------------------------------------------------------------
module cylinder_quad_index_generator_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cqig_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int LATENCY         = 1;
    localparam int STUCK_LIMIT     = 2000;
    localparam int RANDOM_MESHES   = 9;
    localparam int ITEMS_PER_MESH  = 92;
    localparam int RESTART_PCT     = 3;
    localparam int HOLD_AT_QUAD    = 150;
    localparam int HOLD_CYCLES     = 64;
    localparam int DIRECTED_COUNT  = 34;

    typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [1:0]       reg_idx;
        logic [CFG_W-1:0] value;
        logic             req_restart;
        logic             typed;
        quad_t            want;
    } dir_row_t;

    // Typed quads can be read straight off the sequence definition; the rest
    // come from the in-bench model.
    localparam dir_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // reset sizes: 16 around, 2 rings, open
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b1, '{21'd0, 21'd16, 21'd17, 21'd1, SEC_BODY, 1'b0}},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b1, '{21'd1, 21'd17, 21'd18, 21'd2, SEC_BODY, 1'b0}},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b1, 1'b1, '{21'd0, 21'd16, 21'd17, 21'd1, SEC_BODY, 1'b0}},
        // smallest open mesh, wraps and starts over
        '{ROW_CFG, REG_AROUND, 11'd2, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b1, '{21'd0, 21'd2, 21'd3, 21'd1, SEC_BODY, 1'b0}},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b1, '{21'd1, 21'd3, 21'd2, 21'd0, SEC_BODY, 1'b1}},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b1, '{21'd0, 21'd2, 21'd3, 21'd1, SEC_BODY, 1'b0}},
        // smallest closed mesh: one cap quad at each end
        '{ROW_CFG, REG_CLOSED, 11'd1, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b1, '{21'd4, 21'd0, 21'd1, 21'd0, SEC_BOTTOM, 1'b0}},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b1, '{21'd5, 21'd2, 21'd3, 21'd2, SEC_TOP, 1'b1}},
        // size below range saturates, restart in closed mode
        '{ROW_CFG, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b1, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        // odd vertex count: caps round down, whole mesh
        '{ROW_CFG, REG_AROUND, 11'd5, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_RINGS,  11'd1, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        // largest mesh, bottom center at vertex 1048576 (1024 around times 1024 rings)
        '{ROW_CFG, REG_AROUND, 11'd1024, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_RINGS,  11'd1024, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b1,
          '{21'd1048576, 21'd0, 21'd1, 21'd2, SEC_BOTTOM, 1'b0}},
        // sizes above range saturate
        '{ROW_CFG, REG_AROUND, 11'd2047, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_RINGS,  11'd2047, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_CLOSED, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_AROUND, 11'd0, 1'b0, 1'b1, '{21'd0, 21'd1024, 21'd1025, 21'd1, SEC_BODY, 1'b0}}
    };

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              req_valid  = 1'b0;
    logic              req_stall;
    logic              restart    = 1'b0;
    logic              quad_valid;
    logic              quad_stall = 1'b0;
    logic [IDX_W-1:0]  idx_a;
    logic [IDX_W-1:0]  idx_b;
    logic [IDX_W-1:0]  idx_c;
    logic [IDX_W-1:0]  idx_d;
    logic [SEC_W-1:0]  section;
    logic              last_quad;

    // configuration and sequence position as the model sees them
    logic [CFG_W-1:0] cfg_around = AROUND_RST;
    logic [CFG_W-1:0] cfg_rings  = RINGS_RST;
    logic             cfg_closed = 1'b0;
    logic [SEC_W-1:0] pos_phase  = SEC_BODY;
    int               pos_column = 0;
    int               pos_row    = 0;
    int               pos_base   = 0;

    quad_t expected_quads [$];
    quad_t want_quad;

    int src_idle_pct   = 8;
    int sink_stall_pct = 52;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int stuck_cycles   = 0;

    int mismatch_count = 0;
    int req_count      = 0;
    int quad_count     = 0;
    int mesh_settings  = 0;
    int mesh_ends      = 0;
    int section_count [3] = '{0, 0, 0};

    cylinder_quad_index_generator_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .restart    (restart),
        .quad_valid (quad_valid),
        .quad_stall (quad_stall),
        .idx_a      (idx_a),
        .idx_b      (idx_b),
        .idx_c      (idx_c),
        .idx_d      (idx_d),
        .section    (section),
        .last_quad  (last_quad)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void restart_mesh_pos();
        pos_phase  = cfg_closed ? SEC_BOTTOM : SEC_BODY;
        pos_column = 0;
        pos_row    = 0;
        pos_base   = 0;
    endfunction

    // Next quad of the mesh; advances the sequence position.
    function automatic quad_t predict_quad(input logic req_restart);
        int    n;
        int    r;
        int    caps;
        int    center;
        int    s;
        int    j;
        int    x;
        int    a;
        int    b;
        int    c;
        int    d;
        bit    fin;
        bit    wrap;
        quad_t q;
        n = int'(cfg_around);
        if (n < 2) n = 2;
        if (n > MAX_AROUND) n = MAX_AROUND;
        r = int'(cfg_rings);
        if (r < 2) r = 2;
        if (r > MAX_RINGS) r = MAX_RINGS;
        caps   = n / 2;
        center = n * r;
        if (req_restart) restart_mesh_pos();
        if (!cfg_closed && pos_phase != SEC_BODY) restart_mesh_pos();
        q = '0;
        q.section = pos_phase;
        x = pos_column;
        if (pos_phase == SEC_BOTTOM)
        begin
            j   = 2 * x;
            fin = (x + 1 >= caps);
            a   = center;
            b   = j;
            c   = j + 1;
            d   = fin ? 0 : j + 2;
            if (fin)
            begin
                pos_phase  = SEC_BODY;
                pos_column = 0;
                pos_row    = 0;
                pos_base   = 0;
            end
            else
                pos_column++;
        end
        else if (pos_phase == SEC_TOP)
        begin
            s   = center - n;
            j   = s + 2 * x;
            fin = (x + 1 >= caps);
            a   = center + 1;
            b   = fin ? s : j + 2;
            c   = j + 1;
            d   = j;
            if (fin)
            begin
                q.last_quad = 1'b1;
                restart_mesh_pos();
            end
            else
                pos_column++;
        end
        else
        begin
            wrap = (x + 1 >= n);
            a    = pos_base + x;
            b    = pos_base + n + x;
            c    = wrap ? pos_base + n : pos_base + n + x + 1;
            d    = wrap ? pos_base : pos_base + x + 1;
            if (!wrap)
                pos_column++;
            else if (pos_row + 2 >= r)
            begin
                if (cfg_closed)
                begin
                    pos_phase  = SEC_TOP;
                    pos_column = 0;
                    pos_row    = 0;
                    pos_base   = 0;
                end
                else
                begin
                    q.last_quad = 1'b1;
                    restart_mesh_pos();
                end
            end
            else
            begin
                pos_column = 0;
                pos_row++;
                pos_base += n;
            end
        end
        q.idx_a = a[IDX_W-1:0];
        q.idx_b = b[IDX_W-1:0];
        q.idx_c = c[IDX_W-1:0];
        q.idx_d = d[IDX_W-1:0];
        return q;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    // with req_valid still high.
    task automatic send_request(input logic req_restart, input logic typed, input quad_t want);
        quad_t q;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        restart   <= req_restart;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        q = predict_quad(req_restart);
        expected_quads.push_back(typed ? want : q);
        req_count++;
        @(negedge clk);
    endtask

    // Drop the request and let every quad in flight drain.
    task automatic drain_quads();
        req_valid <= 1'b0;
        while (expected_quads.size() != 0) @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    // Register write followed by a read-back; block must be idle.
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        logic [DATA_W-1:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_AROUND: cfg_around = value;
            REG_RINGS:  cfg_rings  = value;
            default:    cfg_closed = value[0];
        endcase
        restart_mesh_pos();
        stored = (idx == REG_CLOSED) ? DATA_W'(value[0]) : DATA_W'(value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== stored)
        begin
            $display("%0t: register %0d read-back mismatch, expected %0d, got %0d",
                     $time, idx, stored, prdata);
            mismatch_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // psel low between back-to-back accesses
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // quad side: random stalls plus one long hold while requests keep coming
    always @(negedge clk)
    begin
        if (!hold_done && quad_count >= HOLD_AT_QUAD)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            quad_stall <= 1'b1;
            hold_left--;
        end
        else
            quad_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && quad_valid && !quad_stall)
        begin
            quad_count++;
            if (expected_quads.size() == 0)
            begin
                $display("%0t: quad transfer with none expected, got %0d %0d %0d %0d sec %0d last %0d",
                         $time, idx_a, idx_b, idx_c, idx_d, section, last_quad);
                mismatch_count++;
            end
            else
            begin
                want_quad = expected_quads.pop_front();
                check_field("idx_a", int'(want_quad.idx_a), int'(idx_a));
                check_field("idx_b", int'(want_quad.idx_b), int'(idx_b));
                check_field("idx_c", int'(want_quad.idx_c), int'(idx_c));
                check_field("idx_d", int'(want_quad.idx_d), int'(idx_d));
                check_field("section", int'(want_quad.section), int'(section));
                check_field("last_quad", int'(want_quad.last_quad), int'(last_quad));
                if (want_quad.section <= SEC_TOP) section_count[want_quad.section]++;
                if (want_quad.last_quad) mesh_ends++;
            end
        end
    end

    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (quad_valid && !quad_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int               mix;
        int               k;
        int               pick;
        logic [CFG_W-1:0] around;
        logic [CFG_W-1:0] ring_cnt;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG)
            begin
                drain_quads();
                write_reg(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].value);
                mesh_settings++;
            end
            else
                send_request(DIRECTED_ROWS[i].req_restart, DIRECTED_ROWS[i].typed,
                             DIRECTED_ROWS[i].want);
        end

        for (mix = 0; mix < 3; mix++)
        begin
            src_idle_pct   = (mix == 0) ? 8 : (mix == 1) ? 52 : 0;
            sink_stall_pct = (mix == 0) ? 52 : (mix == 1) ? 8 : 0;
            for (k = 0; k < RANDOM_MESHES / 3; k++)
            begin
                pick = $urandom_range(9);
                if (pick == 0)
                begin
                    around   = CFG_W'($urandom_range(0, 2047));
                    ring_cnt = CFG_W'($urandom_range(0, 2047));
                end
                else if (pick == 1)
                begin
                    around   = CFG_W'($urandom_range(0, 1));
                    ring_cnt = CFG_W'($urandom_range(0, 1));
                end
                else
                begin
                    // small meshes so that caps, wraps and mesh ends recur
                    around   = CFG_W'($urandom_range(2, 9));
                    ring_cnt = CFG_W'($urandom_range(2, 5));
                end
                drain_quads();
                write_reg(REG_AROUND, around);
                write_reg(REG_RINGS, ring_cnt);
                write_reg(REG_CLOSED, CFG_W'($urandom_range(1)));
                mesh_settings++;
                repeat (ITEMS_PER_MESH)
                    send_request($urandom_range(99) < RESTART_PCT, 1'b0, '0);
            end
        end

        drain_quads();
        repeat (LATENCY + 4) @(negedge clk);

        $display("Covered %0d requests and %0d quads over %0d mesh settings, with long output hold.",
                 req_count, quad_count, mesh_settings);
        $display("Quads by section: %0d bottom cap, %0d body, %0d top cap; %0d mesh ends.",
                 section_count[0], section_count[1], section_count[2], mesh_ends);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
